// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the biquad filter checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BQF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bqf assertion failed");

// next-cycle implication, disabled while reset is asserted
`define BQF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bqf assertion failed");

`endif

// File: rtl/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// widths, register codes and shared types of the multichannel biquad filter
// ----------------------------------------------------------------------------
`default_nettype none

package bqf_pkg;

    localparam int SAMPLE_W             = 24;
    localparam int CHAN_W               = 3;
    localparam int COEF_W               = 32;
    localparam int REG_IDX_W            = 3;
    localparam int PROD_W               = SAMPLE_W + COEF_W;
    localparam int ACC_W                = PROD_W + 3;
    localparam int FRAC_SHIFT           = 29;
    localparam int DEFAULT_NUM_CHANNELS = 8;
    localparam int MAX_IN_FLIGHT        = 4;

    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_SHIFT);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] b0;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] a2;
    } coef_set_t;

    // one channel's filter history, one memory word
    typedef struct packed {
        logic [SAMPLE_W-1:0] x1;
        logic [SAMPLE_W-1:0] x2;
        logic [SAMPLE_W-1:0] y1;
        logic [SAMPLE_W-1:0] y2;
    } hist_t;

    localparam int HIST_W = $bits(hist_t);

    typedef struct packed {
        logic s2_load;
        logic s3_load;
    } stage_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bqf_ram.sv
// ----------------------------------------------------------------------------
// bqf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/bqf_round.sv
// ----------------------------------------------------------------------------
// bqf_round
// round the q.52 sum to q1.23, ties up, and saturate to the sample range
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_round import bqf_pkg::*; (
    input  wire logic [ACC_W-1:0]    acc,
    output logic      [SAMPLE_W-1:0] y
);

    localparam int Q_W = ACC_W + 1 - FRAC_SHIFT;

    localparam logic signed [ACC_W:0]   ROUND_BIAS = (ACC_W+1)'(1 << (FRAC_SHIFT - 1));
    localparam logic signed [Q_W-1:0]   SAT_MAX    = Q_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SAT_MIN    = -Q_W'(1 << (SAMPLE_W - 1));
    localparam logic [SAMPLE_W-1:0]     Y_MAX      = SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic [SAMPLE_W-1:0]     Y_MIN      = SAMPLE_W'(1 << (SAMPLE_W - 1));

    logic signed [ACC_W:0]  biased;
    logic signed [Q_W-1:0]  q;

    assign biased = $signed({acc[ACC_W-1], acc}) + ROUND_BIAS;
    assign q      = $signed(biased[ACC_W:FRAC_SHIFT]);

    always_comb
    begin
        if (q > SAT_MAX)
        begin
            y = Y_MAX;
        end
        else if (q < SAT_MIN)
        begin
            y = Y_MIN;
        end
        else
        begin
            y = q[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bqf_mac.sv
// ----------------------------------------------------------------------------
// bqf_mac
// five products into stage 2, signed sum into stage 3, history carried along
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_mac import bqf_pkg::*; (
    input  wire logic                clk,
    input  wire stage_ctl_t          ctl,
    input  wire coef_set_t           coefs,
    input  wire logic [SAMPLE_W-1:0] x,
    input  wire hist_t               hist,
    output logic      [ACC_W-1:0]    acc,
    output logic      [SAMPLE_W-1:0] s3_x,
    output logic      [SAMPLE_W-1:0] s3_x1,
    output logic      [SAMPLE_W-1:0] s3_y1
);

    logic signed [PROD_W-1:0] p_b0_reg, p_b1_reg, p_b2_reg, p_a1_reg, p_a2_reg;
    logic signed [PROD_W-1:0] p_b0_next, p_b1_next, p_b2_next, p_a1_next, p_a2_next;
    logic [SAMPLE_W-1:0]      s2_x_reg, s2_x1_reg, s2_y1_reg;
    logic [SAMPLE_W-1:0]      s3_x_reg, s3_x1_reg, s3_y1_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    assign p_b0_next = $signed(coefs.b0) * $signed(x);
    assign p_b1_next = $signed(coefs.b1) * $signed(hist.x1);
    assign p_b2_next = $signed(coefs.b2) * $signed(hist.x2);
    assign p_a1_next = $signed(coefs.a1) * $signed(hist.y1);
    assign p_a2_next = $signed(coefs.a2) * $signed(hist.y2);

    // exact sum, feedback terms subtracted
    assign acc_next = ACC_W'(p_b0_reg) + ACC_W'(p_b1_reg) + ACC_W'(p_b2_reg)
                    - ACC_W'(p_a1_reg) - ACC_W'(p_a2_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.s2_load)
        begin
            p_b0_reg  <= p_b0_next;
            p_b1_reg  <= p_b1_next;
            p_b2_reg  <= p_b2_next;
            p_a1_reg  <= p_a1_next;
            p_a2_reg  <= p_a2_next;
            s2_x_reg  <= x;
            s2_x1_reg <= hist.x1;
            s2_y1_reg <= hist.y1;
        end
        if (ctl.s3_load)
        begin
            acc_reg   <= acc_next;
            s3_x_reg  <= s2_x_reg;
            s3_x1_reg <= s2_x1_reg;
            s3_y1_reg <= s2_y1_reg;
        end
    end

    assign acc   = acc_reg;
    assign s3_x  = s3_x_reg;
    assign s3_x1 = s3_x1_reg;
    assign s3_y1 = s3_y1_reg;

endmodule

`default_nettype wire

// File: rtl/multichannel_biquad_filter.sv
// ----------------------------------------------------------------------------
// multichannel_biquad_filter
// direct form i biquad shared by up to NUM_CHANNELS channels, history in ram
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ------------------------
//  req       req_valid / req_stall  sample_in, channel_sel
//  rsp       rsp_valid / rsp_stall  sample_out, channel_out
//  cfg       cfg_we                 cfg_index, cfg_data
//
//  a req transfer moves through stages 1, 2 and 3 to rsp_valid: ram read on
//    the transfer edge, then products, sum, and round, saturate and write back
//    into the output register
//  one transfer per cycle unless stalled or a channel is still in stage 1 or 2
//  the same channel can be taken again once its previous item sits in the
//    last stage and is not stalled, a limit set by the y1 feedback loop
//  reset clears coefficients to a unity pass and all history via valid bits
//  rsp_stall only stops stages that are full; bubbles close up underneath
//
`default_nettype none

module multichannel_biquad_filter import bqf_pkg::*; #(
    parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [COEF_W-1:0]    cfg_data,
    // sample requests
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire logic [SAMPLE_W-1:0]  sample_in,
    input  wire logic [CHAN_W-1:0]    channel_sel,
    // filtered results
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output logic      [SAMPLE_W-1:0]  sample_out,
    output logic      [CHAN_W-1:0]    channel_out
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // coefficient registers
    coef_set_t coef_reg;

    // stage valids (control)
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, rsp_valid_reg;

    // stage tags and payload
    logic [CHAN_W-1:0]   s1_ch_reg, s2_ch_reg, s3_ch_reg;
    logic                s1_inr_reg, s2_inr_reg, s3_inr_reg;
    logic [SAMPLE_W-1:0] s1_x_reg;
    logic                s1_fwd_reg;
    logic                s1_hvalid_reg;
    hist_t               s1_fwd_data_reg;
    logic [SAMPLE_W-1:0] sample_out_reg;
    logic [CHAN_W-1:0]   channel_out_reg;

    // per-channel "history written" bits; an unwritten channel reads as zero
    logic [NUM_CHANNELS-1:0] hist_valid_reg;

    logic                req_accept;
    logic                req_inr;
    logic [AW-1:0]       req_addr;
    logic                match_s1, match_s2, match_s3;
    logic                hazard;
    logic                out_free, s3_free, s2_free, s1_free;
    logic                s3_adv;
    stage_ctl_t          stage_ctl;

    hist_t               ram_rdata;
    hist_t               s1_hist;
    hist_t               wb_hist;
    logic                wb_we;
    logic [AW-1:0]       wb_addr;

    logic [ACC_W-1:0]    acc;
    logic [SAMPLE_W-1:0] s3_x, s3_x1, s3_y1;
    logic [SAMPLE_W-1:0] y;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= COEF_ONE;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_B0:  coef_reg.b0 <= cfg_data;
                REG_B1:  coef_reg.b1 <= cfg_data;
                REG_B2:  coef_reg.b2 <= cfg_data;
                REG_A1:  coef_reg.a1 <= cfg_data;
                REG_A2:  coef_reg.a2 <= cfg_data;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage flow: each stage moves when the one after it has room
    // ------------------------------------------------------------------
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign s3_adv   = s3_valid_reg && out_free;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign stage_ctl.s2_load = s1_valid_reg && s2_free;
    assign stage_ctl.s3_load = s2_valid_reg && s3_free;

    // ------------------------------------------------------------------
    // request side: range check and same-channel interlock
    // ------------------------------------------------------------------
    assign req_addr = AW'(channel_sel);
    assign req_inr  = (32'(channel_sel) < NUM_CHANNELS);

    assign match_s1 = s1_valid_reg && s1_inr_reg && (s1_ch_reg == channel_sel);
    assign match_s2 = s2_valid_reg && s2_inr_reg && (s2_ch_reg == channel_sel);
    assign match_s3 = s3_valid_reg && s3_inr_reg && (s3_ch_reg == channel_sel);

    // an item that leaves the last stage writes back on the transfer edge, so its
    // word is forwarded; a stalled one or anything earlier holds the request off
    assign hazard = req_inr && (match_s1 || match_s2 || (match_s3 && !out_free));

    assign req_stall  = !s1_free || hazard;
    assign req_accept = req_valid && !req_stall;

    // ------------------------------------------------------------------
    // history memory
    // ------------------------------------------------------------------
    assign wb_we      = s3_adv && s3_inr_reg;
    assign wb_addr    = AW'(s3_ch_reg);
    assign wb_hist.x1 = s3_x;
    assign wb_hist.x2 = s3_x1;
    assign wb_hist.y1 = y;
    assign wb_hist.y2 = s3_y1;

    bqf_ram #(
        .WIDTH (HIST_W),
        .DEPTH (NUM_CHANNELS),
        .AW    (AW)
    ) u_hist_ram (
        .clk   (clk),
        .we    (wb_we),
        .waddr (wb_addr),
        .wdata (wb_hist),
        .re    (req_accept && req_inr),
        .raddr (req_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
        end
        else if (wb_we)
        begin
            hist_valid_reg[wb_addr] <= 1'b1;
        end
    end

    // history seen by stage 1: forwarded word, memory word, or zero if unwritten
    always_comb
    begin
        if (s1_fwd_reg)
        begin
            s1_hist = s1_fwd_data_reg;
        end
        else if (s1_hvalid_reg)
        begin
            s1_hist = ram_rdata;
        end
        else
        begin
            s1_hist = '0;
        end
    end

    // ------------------------------------------------------------------
    // stage valids
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= req_accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                rsp_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage tags and payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_ch_reg       <= channel_sel;
            s1_inr_reg      <= req_inr;
            s1_x_reg        <= sample_in;
            s1_fwd_reg      <= req_inr && match_s3;
            s1_fwd_data_reg <= wb_hist;
            s1_hvalid_reg   <= req_inr && hist_valid_reg[req_addr];
        end
        if (stage_ctl.s2_load)
        begin
            s2_ch_reg  <= s1_ch_reg;
            s2_inr_reg <= s1_inr_reg;
        end
        if (stage_ctl.s3_load)
        begin
            s3_ch_reg  <= s2_ch_reg;
            s3_inr_reg <= s2_inr_reg;
        end
        if (s3_adv)
        begin
            // out-of-range channels return zero and touch no history
            sample_out_reg  <= s3_inr_reg ? y : '0;
            channel_out_reg <= s3_ch_reg;
        end
    end

    // ------------------------------------------------------------------
    // arithmetic
    // ------------------------------------------------------------------
    bqf_mac u_mac (
        .clk   (clk),
        .ctl   (stage_ctl),
        .coefs (coef_reg),
        .x     (s1_x_reg),
        .hist  (s1_hist),
        .acc   (acc),
        .s3_x  (s3_x),
        .s3_x1 (s3_x1),
        .s3_y1 (s3_y1)
    );

    bqf_round u_round (
        .acc (acc),
        .y   (y)
    );

    assign rsp_valid   = rsp_valid_reg;
    assign sample_out  = sample_out_reg;
    assign channel_out = channel_out_reg;

endmodule

`default_nettype wire

// File: rtl/bqf_checker.sv
// ----------------------------------------------------------------------------
// bqf_checker
// port-level checks on the multichannel biquad filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bqf_checker import bqf_pkg::*; #(
    parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_stall,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_stall,
    input wire logic [SAMPLE_W-1:0]  sample_out,
    input wire logic [CHAN_W-1:0]    channel_out
);

    localparam int PEND_W = $clog2(MAX_IN_FLIGHT + 2);

    logic [PEND_W-1:0]          pending_reg, pending_next;
    logic                       req_xfer, rsp_xfer;
    logic                       rsp_stalled;
    logic                       oor_out;
    logic [SAMPLE_W+CHAN_W-1:0] rsp_word;

    assign req_xfer    = req_valid && !req_stall;
    assign rsp_xfer    = rsp_valid && !rsp_stall;
    assign rsp_stalled = rsp_valid && rsp_stall;
    assign rsp_word    = {sample_out, channel_out};
    assign oor_out     = rsp_valid && (32'(channel_out) >= NUM_CHANNELS);

    always_comb
    begin
        pending_next = pending_reg;
        if (req_xfer && !rsp_xfer)
        begin
            pending_next = pending_reg + PEND_W'(1);
        end
        else if (rsp_xfer && !req_xfer)
        begin
            pending_next = pending_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result holds
    `BQF_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_stalled, rsp_valid && $stable(rsp_word))

    // no result without an outstanding request
    `BQF_ASSERT_IMP(a_rsp_has_req, clk, rst_n, rsp_valid, pending_reg != '0)

    // the pipe never holds more items than it has stages
    `BQF_ASSERT_IMP(a_depth, clk, rst_n, 1'b1, pending_reg <= PEND_W'(MAX_IN_FLIGHT))

    // an empty pipe takes a request at once
    `BQF_ASSERT_IMP(a_empty_ready, clk, rst_n, pending_reg == '0, !req_stall)

    // channels without a filter return silence
    `BQF_ASSERT_IMP(a_oor_zero, clk, rst_n, oor_out, sample_out == '0)

endmodule

bind multichannel_biquad_filter bqf_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_bqf_checker (.*);

`default_nettype wire
